### rtl/core/flha_pkg.sv
// ----------------------------------------------------------------------------
// flha_pkg: shared definitions of the free-list heap allocator
// Command codes, the header word kept for every arena unit, and the
// one-hot state codes of the allocator sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package flha_pkg;

  localparam logic [1:0] CMD_ALLOC  = 2'd0;
  localparam logic [1:0] CMD_FREE   = 2'd1;
  localparam logic [1:0] CMD_CALLOC = 2'd2;

  // One header per unit: block size in units and link to the next free block.
  typedef struct packed {
    logic [31:0] size;
    logic [15:0] link;
  } hdr_t;

  localparam int HDR_W = $bits(hdr_t);

  typedef enum logic [18:0] {
    ST_IDLE     = 19'h00001,
    ST_MUL      = 19'h00002,
    ST_DIV      = 19'h00004,
    ST_INIT     = 19'h00008,
    ST_A_START  = 19'h00010,
    ST_A_PREV   = 19'h00020,
    ST_A_P      = 19'h00040,
    ST_A_CUT    = 19'h00080,
    ST_A_REGROW = 19'h00100,
    ST_A_RELINK = 19'h00200,
    ST_ZERO     = 19'h00400,
    ST_FREE     = 19'h00800,
    ST_F_CHK    = 19'h01000,
    ST_R_START  = 19'h02000,
    ST_R_WALK   = 19'h04000,
    ST_R_B      = 19'h08000,
    ST_R_NX     = 19'h10000,
    ST_R_P      = 19'h20000,
    ST_DONE     = 19'h40000
  } state_t;

endpackage

`default_nettype wire

### rtl/core/flha_ram.sv
// ----------------------------------------------------------------------------
// flha_ram: generic simple dual-port RAM
// One write port and one read port; the read data is registered, so it
// appears in the cycle after the address. A read at the address being written
// in the same cycle returns the old contents.
// ----------------------------------------------------------------------------
`default_nettype none

module flha_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/core/free_list_heap_allocator_top.sv
// ----------------------------------------------------------------------------
// free_list_heap_allocator_top: next-fit free-list heap allocator
// Serves allocate, free and zeroed-allocate requests over a unit arena whose
// headers live in one on-chip RAM, with a sequencer that walks the list.
// ----------------------------------------------------------------------------
// A request word carries a command and its operands; every word, whatever
// the command, produces exactly one result word. Allocation returns the
// payload unit index of the granted block, or sets failed; free and the
// unused command return address 0 with failed clear. The arena headers sit
// in a single RAM with a registered read, and all list traversal goes
// through its one read port, one node per cycle. An allocation first
// converts bytes to units with a multiply by the reciprocal of the unit
// size; a rounded-up byte count of 2^21 or more is taken as a request
// that can never fit, since no block can hold that many units. It then
// sets up the search, visits the free-list nodes from the rover, and
// splits (where larger) and writes back the block before it hands over the
// result; when the search wraps and the arena grows, the new block is
// first inserted into the list by a further walk and the search resumes.
// A zeroed allocation adds a multiply of item count by item size and
// clears the payload units one by one. A free checks the block against
// the arena, walks the list to its insertion point and merges with free
// neighbours. A new request is taken only once the previous one has
// finished, but the result register lets the next request start while
// the last result still waits downstream. The RAM gets no clearing pass,
// so a free of an address that is not a granted block can read a unit
// that has never been written.
// ----------------------------------------------------------------------------
`default_nettype none

module free_list_heap_allocator_top #(
  parameter int ARENA_UNITS = 65536,
  parameter int GROW_UNITS  = 1024,
  parameter int UNIT_BYTES  = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic [31:0] byte_count,
  input  logic [31:0] item_count,
  input  logic [31:0] item_size,
  input  logic [15:0] block_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] payload_address,
  output logic        failed
);

  import flha_pkg::*;

  localparam int IW         = $clog2(ARENA_UNITS);
  localparam int WALK_LIMIT = 3 * ARENA_UNITS + 8;
  localparam int SW         = $clog2(WALK_LIMIT + 1);

  // Reciprocal of the unit size, exact for dividends below 2^DIV_N.
  localparam int     DIV_N = 21;
  localparam int     DIV_S = DIV_N + $clog2(UNIT_BYTES);
  localparam longint DIV_M = ((longint'(1) << DIV_S) + UNIT_BYTES - 1) / UNIT_BYTES;

  localparam logic [32:0]      UB_M1     = 33'(UNIT_BYTES - 1);
  localparam logic [DIV_N+1:0] RECIP     = (DIV_N + 2)'(DIV_M);
  localparam logic [32:0]      NEED_SAT  = 33'h1_0000_0000;
  localparam logic [32:0]      GROW_T    = 33'(GROW_UNITS);
  localparam logic [33:0]      ARENA_TOP = 34'(ARENA_UNITS - 1);
  localparam logic [SW-1:0]    LIMIT_T   = SW'(WALK_LIMIT);

  // Sequencer and working registers.
  state_t        state, state_next;
  logic [1:0]    cmd_r, cmd_r_next;
  logic [63:0]   prod, prod_next;
  logic [32:0]   div_q, div_q_next;
  logic [32:0]   need, need_next;
  logic [15:0]   rover, rover_next;
  logic          started, started_next;
  logic [16:0]   brk, brk_next;
  logic [15:0]   prev, prev_next;
  logic [31:0]   prev_sz, prev_sz_next;
  logic [15:0]   p, p_next;
  logic [31:0]   cut_sz, cut_sz_next;
  logic [SW-1:0] steps, steps_next;
  logic [SW-1:0] rsteps, rsteps_next;
  logic [15:0]   blk, blk_next;
  logic [15:0]   rp, rp_next;
  logic [15:0]   rnx, rnx_next;
  logic [31:0]   rpsz, rpsz_next;
  logic [31:0]   rbsz, rbsz_next;
  logic [15:0]   rbnext, rbnext_next;
  logic [16:0]   zi, zi_next;
  logic [15:0]   res, res_next;
  logic [15:0]   fin_addr, fin_addr_next;
  logic          fin_fail, fin_fail_next;
  logic          out_valid_next;
  logic [15:0]   out_addr, out_addr_next;
  logic          out_fail, out_fail_next;

  // RAM port signals.
  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  hdr_t          ram_wdata;
  logic [IW-1:0] ram_raddr;
  logic [HDR_W-1:0] ram_rdata;
  hdr_t          rd;

  assign rd = hdr_t'(ram_rdata);

  flha_ram #(
    .WIDTH (HDR_W),
    .DEPTH (ARENA_UNITS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_stall        = (state != ST_IDLE);
  assign payload_address = out_addr;
  assign failed          = out_fail;

  always_comb begin
    logic [2*DIV_N+1:0] recip_prod;
    logic [32:0]   q_step;
    logic [32:0]   nu;
    logic [33:0]   grow_end;
    logic [15:0]   p2;
    logic [15:0]   fb;
    logic          brk_here;

    state_next    = state;
    cmd_r_next    = cmd_r;
    prod_next     = prod;
    div_q_next    = div_q;
    need_next     = need;
    rover_next    = rover;
    started_next  = started;
    brk_next      = brk;
    prev_next     = prev;
    prev_sz_next  = prev_sz;
    p_next        = p;
    cut_sz_next   = cut_sz;
    steps_next    = steps;
    rsteps_next   = rsteps;
    blk_next      = blk;
    rp_next       = rp;
    rnx_next      = rnx;
    rpsz_next     = rpsz;
    rbsz_next     = rbsz;
    rbnext_next   = rbnext;
    zi_next       = zi;
    res_next      = res;
    fin_addr_next = fin_addr;
    fin_fail_next = fin_fail;
    out_valid_next = out_valid & out_stall;
    out_addr_next = out_addr;
    out_fail_next = out_fail;

    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = '0;

    recip_prod = div_q[DIV_N-1:0] * RECIP;
    q_step     = 33'(recip_prod >> DIV_S);
    nu         = (need < GROW_T) ? GROW_T : need;
    grow_end   = {17'd0, brk} + {1'b0, nu};
    p2         = p + cut_sz[15:0];
    fb         = blk_next;
    brk_here   = 1'b0;

    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd_r_next   = cmd;
          prod_next    = item_count * item_size;
          div_q_next   = {1'b0, byte_count} + UB_M1;
          blk_next     = block_address - 16'd1;
          fin_addr_next = '0;
          fin_fail_next = 1'b0;
          case (cmd)
            CMD_ALLOC:  state_next = ST_DIV;
            CMD_CALLOC: state_next = ST_MUL;
            CMD_FREE:   state_next = ST_FREE;
            default:    state_next = ST_DONE;
          endcase
          if (cmd == CMD_FREE && (!started || block_address == 16'd0)) begin
            state_next = ST_DONE;
          end
        end
      end

      ST_MUL: begin
        if (prod[63:32] != 32'd0) begin
          fin_fail_next = 1'b1;
          state_next    = ST_DONE;
        end else begin
          div_q_next = {1'b0, prod[31:0]} + UB_M1;
          state_next = ST_DIV;
        end
      end

      // Units needed: rounded-up bytes over the unit size, plus the header.
      // Anything too large for the arena is pinned to a size that never fits.
      ST_DIV: begin
        if (div_q[32:DIV_N] != '0) begin
          need_next = NEED_SAT;
        end else begin
          need_next = q_step + 33'd1;
        end
        state_next = ST_INIT;
      end

      ST_INIT: begin
        steps_next = '0;
        if (!started) begin
          ram_we       = 1'b1;
          ram_waddr    = '0;
          ram_wdata    = '0;
          rover_next   = '0;
          started_next = 1'b1;
        end
        state_next = ST_A_START;
      end

      ST_A_START: begin
        ram_raddr  = rover[IW-1:0];
        state_next = ST_A_PREV;
      end

      ST_A_PREV: begin
        prev_next    = rover;
        prev_sz_next = rd.size;
        p_next       = rd.link;
        ram_raddr    = rd.link[IW-1:0];
        state_next   = ST_A_P;
      end

      // Header of the candidate block is on the read port.
      ST_A_P: begin
        if ({1'b0, rd.size} >= need) begin
          if ({1'b0, rd.size} == need) begin
            ram_we      = 1'b1;
            ram_waddr   = prev[IW-1:0];
            ram_wdata   = '{size: prev_sz, link: rd.link};
            rover_next  = prev;
            res_next    = p;
            zi_next     = 17'd1;
            if (cmd_r == CMD_CALLOC) begin
              state_next = ST_ZERO;
            end else begin
              fin_addr_next = p + 16'd1;
              state_next    = ST_DONE;
            end
          end else begin
            cut_sz_next = rd.size - need[31:0];
            ram_we      = 1'b1;
            ram_waddr   = p[IW-1:0];
            ram_wdata   = '{size: rd.size - need[31:0], link: rd.link};
            state_next  = ST_A_CUT;
          end
        end else if (p == rover) begin
          // Search wrapped: extend the arena at the break.
          if (grow_end > ARENA_TOP) begin
            fin_fail_next = 1'b1;
            state_next    = ST_DONE;
          end else begin
            brk_next   = grow_end[16:0];
            ram_we     = 1'b1;
            ram_waddr  = brk[IW-1:0];
            ram_wdata  = '{size: nu[31:0], link: 16'd0};
            blk_next   = brk[15:0];
            state_next = ST_R_START;
          end
        end else begin
          prev_next    = p;
          prev_sz_next = rd.size;
          p_next       = rd.link;
          if (steps == LIMIT_T) begin
            fin_fail_next = 1'b1;
            state_next    = ST_DONE;
          end else begin
            steps_next = steps + SW'(1);
            ram_raddr  = rd.link[IW-1:0];
          end
        end
      end

      ST_A_CUT: begin
        ram_we     = 1'b1;
        ram_waddr  = p2[IW-1:0];
        ram_wdata  = '{size: need[31:0], link: 16'd0};
        rover_next = prev;
        res_next   = p2;
        zi_next    = 17'd1;
        if (cmd_r == CMD_CALLOC) begin
          state_next = ST_ZERO;
        end else begin
          fin_addr_next = p2 + 16'd1;
          state_next    = ST_DONE;
        end
      end

      ST_ZERO: begin
        if ({16'd0, zi} < need) begin
          ram_we    = 1'b1;
          ram_waddr = IW'(res + zi[15:0]);
          ram_wdata = '0;
          zi_next   = zi + 17'd1;
        end else begin
          fin_addr_next = res + 16'd1;
          state_next    = ST_DONE;
        end
      end

      ST_A_REGROW: begin
        ram_raddr  = rover[IW-1:0];
        state_next = ST_A_RELINK;
      end

      ST_A_RELINK: begin
        prev_next    = rover;
        prev_sz_next = rd.size;
        p_next       = rd.link;
        if (steps == LIMIT_T) begin
          fin_fail_next = 1'b1;
          state_next    = ST_DONE;
        end else begin
          steps_next = steps + SW'(1);
          ram_raddr  = rd.link[IW-1:0];
          state_next = ST_A_P;
        end
      end

      // Free: check the block against the arena before inserting it.
      ST_FREE: begin
        if (blk != 16'd0 && {1'b0, blk} < brk) begin
          ram_raddr  = fb[IW-1:0];
          state_next = ST_F_CHK;
        end else begin
          state_next = ST_DONE;
        end
      end

      ST_F_CHK: begin
        if (rd.size != 32'd0 && ({17'd0, blk} + {1'b0, rd.size}) <= {16'd0, brk}) begin
          state_next = ST_R_START;
        end else begin
          state_next = ST_DONE;
        end
      end

      // Insert block blk into the address-ordered list, coalescing.
      ST_R_START: begin
        rp_next     = rover;
        rsteps_next = '0;
        ram_raddr   = rover[IW-1:0];
        state_next  = ST_R_WALK;
      end

      ST_R_WALK: begin
        brk_here = (blk > rp && blk < rd.link) ||
                   (rp >= rd.link && (blk > rp || blk < rd.link));
        if (brk_here) begin
          rnx_next   = rd.link;
          rpsz_next  = rd.size;
          ram_raddr  = blk[IW-1:0];
          state_next = ST_R_B;
        end else begin
          rp_next = rd.link;
          if (rsteps == LIMIT_T) begin
            fin_fail_next = (cmd_r != CMD_FREE);
            state_next    = ST_DONE;
          end else begin
            rsteps_next = rsteps + SW'(1);
            ram_raddr   = rd.link[IW-1:0];
          end
        end
      end

      ST_R_B: begin
        rbsz_next = rd.size;
        if (({17'd0, blk} + {1'b0, rd.size}) == {17'd0, rnx}) begin
          ram_raddr  = rnx[IW-1:0];
          state_next = ST_R_NX;
        end else begin
          rbnext_next = rnx;
          ram_we      = 1'b1;
          ram_waddr   = blk[IW-1:0];
          ram_wdata   = '{size: rd.size, link: rnx};
          state_next  = ST_R_P;
        end
      end

      ST_R_NX: begin
        rbsz_next   = rbsz + rd.size;
        rbnext_next = rd.link;
        ram_we      = 1'b1;
        ram_waddr   = blk[IW-1:0];
        ram_wdata   = '{size: rbsz + rd.size, link: rd.link};
        state_next  = ST_R_P;
      end

      ST_R_P: begin
        ram_we    = 1'b1;
        ram_waddr = rp[IW-1:0];
        if (({17'd0, rp} + {1'b0, rpsz}) == {17'd0, blk}) begin
          ram_wdata = '{size: rpsz + rbsz, link: rbnext};
        end else begin
          ram_wdata = '{size: rpsz, link: blk};
        end
        rover_next = rp;
        if (cmd_r == CMD_FREE) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_A_REGROW;
        end
      end

      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          out_valid_next = 1'b1;
          out_addr_next  = fin_fail ? 16'd0 : fin_addr;
          out_fail_next  = fin_fail;
          state_next     = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rover     <= '0;
      started   <= 1'b0;
      brk       <= 17'd1;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rover     <= rover_next;
      started   <= started_next;
      brk       <= brk_next;
      out_valid <= out_valid_next;
    end
    cmd_r    <= cmd_r_next;
    prod     <= prod_next;
    div_q    <= div_q_next;
    need     <= need_next;
    prev     <= prev_next;
    prev_sz  <= prev_sz_next;
    p        <= p_next;
    cut_sz   <= cut_sz_next;
    steps    <= steps_next;
    rsteps   <= rsteps_next;
    blk      <= blk_next;
    rp       <= rp_next;
    rnx      <= rnx_next;
    rpsz     <= rpsz_next;
    rbsz     <= rbsz_next;
    rbnext   <= rbnext_next;
    zi       <= zi_next;
    res      <= res_next;
    fin_addr <= fin_addr_next;
    fin_fail <= fin_fail_next;
    out_addr <= out_addr_next;
    out_fail <= out_fail_next;
  end

endmodule

`default_nettype wire

### verif/free_list_heap_allocator_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// free_list_heap_allocator_top_tb: self-checking bench of the heap allocator
// Sends allocate, free and zeroed-allocate request words and checks every
// result word against a local model of the arena, the free list and the
// break pointer. Both sides idle at random, and one phase lets the result
// side hold off for a long stretch so that the block fills up.
// ----------------------------------------------------------------------------
module free_list_heap_allocator_top_tb;
  import flha_pkg::*;

  localparam int          ARENA      = 65536;
  localparam int          GROW       = 1024;
  localparam int          UBYTES     = 8;
  localparam int unsigned WALK_BOUND = 3 * ARENA + 8;
  // A double free walks the whole bound, and an allocation that grows the
  // arena may walk the bound twice, so the watchdog sits well above that.
  localparam int          IDLE_LIMIT = 2000000;
  localparam logic [1:0]  CMD_UNUSED = 2'd3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  cmd = CMD_ALLOC;
  logic [31:0] byte_count = '0;
  logic [31:0] item_count = '0;
  logic [31:0] item_size = '0;
  logic [15:0] block_address = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] payload_address;
  logic        failed;

  free_list_heap_allocator_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .byte_count(byte_count), .item_count(item_count),
    .item_size(item_size), .block_address(block_address),
    .out_valid(out_valid), .out_stall(out_stall),
    .payload_address(payload_address), .failed(failed)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Local arena model. Every unit holds a header word: size in the upper
  // 32 bits, link to the next free block in the low 16 bits.
  // --------------------------------------------------------------------------
  logic [63:0] arena_hdr [ARENA];
  int unsigned rover_unit;
  bit          list_open;
  int unsigned break_unit;

  typedef struct {
    logic [15:0] addr;
    logic        fail;
  } grant_t;

  grant_t grant_queue[$];
  logic [15:0] live_blocks[$];

  int errors = 0;
  int words_sent = 0;
  int grants = 0;
  int refusals = 0;
  int frees_sent = 0;
  int results_seen = 0;
  int hold_cycles = 0;

  function automatic int unsigned hdr_link(int unsigned u);
    return int'(arena_hdr[u & 16'hFFFF][15:0]);
  endfunction

  function automatic longint unsigned hdr_size(int unsigned u);
    return longint'(arena_hdr[u & 16'hFFFF][63:32]);
  endfunction

  function automatic void hdr_write(int unsigned u, int unsigned nx, longint unsigned sz);
    arena_hdr[u & 16'hFFFF] = {sz[31:0], 16'h0000, nx[15:0]};
  endfunction

  // Insert the block at header unit b into the address-ordered list,
  // merging with free neighbours; returns 0 when no insertion point turns up.
  function automatic bit list_insert(int unsigned b);
    int unsigned p, nx, bnext, steps;
    longint unsigned bsz;
    p = rover_unit;
    steps = 0;
    forever begin
      nx = hdr_link(p);
      if (b > p && b < nx) break;
      if (p >= nx && (b > p || b < nx)) break;
      p = nx;
      steps++;
      if (steps > WALK_BOUND) return 1'b0;
    end
    bsz = hdr_size(b);
    if (longint'(b) + bsz == longint'(nx)) begin
      bsz += hdr_size(nx);
      bnext = hdr_link(nx);
    end else begin
      bnext = nx;
    end
    hdr_write(b, bnext, bsz);
    if (longint'(p) + hdr_size(p) == longint'(b))
      hdr_write(p, bnext, hdr_size(p) + bsz);
    else
      hdr_write(p, b, hdr_size(p));
    rover_unit = p;
    return 1'b1;
  endfunction

  // Next-fit search; returns the header unit of the granted block or 0.
  function automatic int unsigned carve_block(longint unsigned nbytes);
    longint unsigned need, sz, nu;
    int unsigned prv, p, steps, up;
    need = (nbytes + UBYTES - 1) / UBYTES + 1;
    steps = 0;
    if (!list_open) begin
      hdr_write(0, 0, 0);
      rover_unit = 0;
      list_open = 1'b1;
    end
    prv = rover_unit;
    p = hdr_link(prv);
    forever begin
      sz = hdr_size(p);
      if (sz >= need) begin
        if (sz == need) begin
          hdr_write(prv, hdr_link(p), hdr_size(prv));
        end else begin
          sz -= need;
          hdr_write(p, hdr_link(p), sz);
          p = (p + int'(sz)) & 16'hFFFF;
          hdr_write(p, 0, need);
        end
        rover_unit = prv;
        return p;
      end
      if (p == rover_unit) begin
        nu = (need < GROW) ? GROW : need;
        up = break_unit;
        if (longint'(break_unit) + nu > ARENA - 1) return 0;
        break_unit = break_unit + int'(nu);
        hdr_write(up, 0, nu);
        if (!list_insert(up)) return 0;
        p = rover_unit;
      end
      prv = p;
      p = hdr_link(p);
      steps++;
      if (steps > WALK_BOUND) return 0;
    end
  endfunction

  // Work out the result word of one accepted request word.
  function automatic grant_t predict_grant(logic [1:0] c, logic [31:0] nb, logic [31:0] ni,
                                           logic [31:0] ns, logic [15:0] ba);
    grant_t g;
    int unsigned hdr, b;
    longint unsigned total, n, sz;
    g.addr = '0;
    g.fail = 1'b0;
    hdr = 0;
    if (c == CMD_FREE) begin
      if (list_open && ba != 0) begin
        b = ba - 1;
        sz = hdr_size(b);
        if (b >= 1 && b < break_unit && sz != 0 && longint'(b) + sz <= break_unit)
          void'(list_insert(b));
      end
      return g;
    end
    if (c == CMD_UNUSED) return g;
    if (c == CMD_ALLOC) begin
      hdr = carve_block(longint'(nb));
      g.fail = (hdr == 0);
    end else begin
      total = longint'(ni) * longint'(ns);
      if (total > 64'hFFFF_FFFF) begin
        g.fail = 1'b1;
      end else begin
        hdr = carve_block(total);
        g.fail = (hdr == 0);
        if (!g.fail) begin
          n = hdr_size(hdr);
          for (longint unsigned i = 1; i < n; i++)
            arena_hdr[(hdr + i) & 16'hFFFF] = '0;
        end
      end
    end
    if (!g.fail) g.addr = 16'(hdr + 1);
    return g;
  endfunction

  // --------------------------------------------------------------------------
  // Request side. The word is predicted at the edge where it is accepted.
  // Valid stays high into the next word when no gap is drawn, so it is never
  // lowered and raised in the same step.
  // --------------------------------------------------------------------------
  task automatic send_word(logic [1:0] c, logic [31:0] nb, logic [31:0] ni,
                           logic [31:0] ns, logic [15:0] ba);
    int gap;
    grant_t g;
    gap = $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    cmd           <= c;
    byte_count    <= nb;
    item_count    <= ni;
    item_size     <= ns;
    block_address <= ba;
    do @(posedge clk); while (in_stall !== 1'b0);
    g = predict_grant(c, nb, ni, ns, ba);
    grant_queue.push_back(g);
    words_sent++;
    if (c == CMD_FREE) frees_sent++;
    else if (c != CMD_UNUSED) begin
      if (g.fail) refusals++;
      else begin
        grants++;
        live_blocks.push_back(g.addr);
      end
    end
  endtask

  // Allocation and free wrappers put random values on the unused fields so
  // that every field bit toggles.
  task automatic alloc_bytes(logic [31:0] nb);
    send_word(CMD_ALLOC, nb, $urandom, $urandom, 16'($urandom));
  endtask

  task automatic alloc_items(logic [31:0] ni, logic [31:0] ns);
    send_word(CMD_CALLOC, $urandom, ni, ns, 16'($urandom));
  endtask

  task automatic free_addr(logic [15:0] ba);
    send_word(CMD_FREE, $urandom, $urandom, $urandom, ba);
  endtask

  // Frees one randomly chosen live block.
  task automatic free_some_live();
    int k;
    logic [15:0] a;
    k = $urandom_range(0, live_blocks.size() - 1);
    a = live_blocks[k];
    live_blocks.delete(k);
    free_addr(a);
  endtask

  // --------------------------------------------------------------------------
  // Result side: a fresh stall is drawn for every result word, and a long
  // hold-off can be requested through hold_cycles.
  // --------------------------------------------------------------------------
  int stall_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) stall_left = $urandom_range(0, 7);
      if (hold_cycles > 0) begin
        hold_cycles = hold_cycles - 1;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left = stall_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Checks each accepted result word against the oldest expectation.
  always @(posedge clk) begin
    grant_t g;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (grant_queue.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result word: addr %h failed %b", payload_address, failed);
      end else begin
        g = grant_queue.pop_front();
        if (payload_address !== g.addr || failed !== g.fail) begin
          errors++;
          if (errors <= 10)
            $display("mismatch at result %0d: expected addr %h failed %b, got addr %h failed %b",
                     results_seen, g.addr, g.fail, payload_address, failed);
        end
      end
    end
  end

  // Watchdog on cycles in which neither side accepts a word.
  int idle_run = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_run = 0;
    else idle_run++;
    if (idle_run >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Words that must change nothing: the unused command, a free before the
  // list exists, and a free of address zero.
  task automatic test_no_effect_words();
    send_word(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
    free_addr(16'd5);
    free_addr(16'd0);
  endtask

  // Small grants, a free that leaves its own node, a double free of that
  // node (walks the full bound and is ignored), then a free that merges on
  // both sides.
  task automatic test_free_and_merge();
    logic [15:0] a, b;
    alloc_bytes(32'd0);
    alloc_bytes(32'd1);
    alloc_bytes(32'd16);
    alloc_bytes(32'd16);
    a = live_blocks[2];
    b = live_blocks[3];
    live_blocks.delete(3);
    live_blocks.delete(2);
    free_addr(a);
    free_addr(a);
    free_addr(b);
  endtask

  // Requests that can never fit and zeroed allocations at the product edges.
  task automatic test_size_extremes();
    alloc_bytes(32'hFFFF_FFFF);
    alloc_items(32'hFFFF_FFFF, 32'd2);
    alloc_items(32'h0001_0000, 32'h0001_0000);
    alloc_items(32'hFFFF_FFFF, 32'd1);
    alloc_items(32'd0, 32'hFFFF_FFFF);
    alloc_items(32'd3, 32'd5);
    alloc_items(32'd1, 32'd0);
  endtask

  // Large blocks until the arena is exhausted, then all of them released.
  task automatic test_arena_exhaustion();
    repeat (9) alloc_bytes(32'd60000);
    while (live_blocks.size() > 0) free_some_live();
  endtask

  // The result side holds off while the request side keeps offering words.
  task automatic test_backpressure();
    hold_cycles = 400;
    repeat (30) begin
      if (live_blocks.size() > 4 && $urandom_range(0, 1)) free_some_live();
      else alloc_bytes($urandom_range(0, 300));
    end
  endtask

  // Mostly well-formed traffic: allocations against frees of live blocks,
  // with a little noise and rare oversized or overflowing requests.
  task automatic test_random_traffic(int n);
    int pick;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (live_blocks.size() > 48) pick = 60;
      if (pick < 36) begin
        if ($urandom_range(0, 29) == 0) alloc_bytes($urandom);
        else if ($urandom_range(0, 19) == 0) alloc_bytes($urandom_range(4000, 60000));
        else alloc_bytes($urandom_range(0, 400));
      end else if (pick < 48) begin
        if ($urandom_range(0, 9) == 0) alloc_items($urandom, $urandom);
        else alloc_items($urandom_range(0, 24), $urandom_range(0, 40));
      end else if (pick < 96 && live_blocks.size() > 0) begin
        free_some_live();
      end else if (pick < 98) begin
        send_word(CMD_UNUSED, $urandom, $urandom, $urandom, 16'($urandom));
      end else begin
        free_addr(16'd0);
      end
    end
  endtask

  initial begin
    rover_unit = 0;
    list_open  = 1'b0;
    break_unit = 1;
    foreach (arena_hdr[i]) arena_hdr[i] = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_no_effect_words();
    test_free_and_merge();
    test_size_extremes();
    test_arena_exhaustion();
    test_backpressure();
    test_random_traffic(1040);
    while (live_blocks.size() > 0) free_some_live();

    in_valid <= 1'b0;
    while (grant_queue.size() > 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (grant_queue.size() > 0) errors++;

    $display("Covered %0d request words: %0d grants, %0d refusals, %0d frees.",
             words_sent, grants, refusals, frees_sent);
    $display("Included merging, double free, arena exhaustion and a long output hold-off.");
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/flha_pkg.sv
rtl/core/flha_ram.sv
rtl/core/free_list_heap_allocator_top.sv
verif/free_list_heap_allocator_top_tb.sv
